FILE: design/nested_record_stream_tokenizer_assert.svh
// Assertion macros used by the tokenizer controller.
`ifndef NESTED_RECORD_STREAM_TOKENIZER_ASSERT_SVH
`define NESTED_RECORD_STREAM_TOKENIZER_ASSERT_SVH
// Property holds on every clock edge outside reset.
`define NRST_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Implication checked on the following clock edge.
`define NRST_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

FILE: design/nrst_pkg.sv
// ----------------------------------------------------------------------------
// nrst_pkg
// Types and constants shared by the tokenizer controller and datapath.
// ----------------------------------------------------------------------------
package nrst_pkg;
	localparam int unsigned StackDepth = 16;
	localparam int unsigned SpW = $clog2(StackDepth + 1);
	localparam int unsigned IdxW = (StackDepth > 1) ? $clog2(StackDepth) : 1;

	typedef enum logic [3:0] {
		TK_NIL = 4'd0, TK_INT = 4'd1, TK_SBYTE = 4'd2, TK_SEND = 4'd3,
		TK_ASTART = 4'd4, TK_HSTART = 4'd5, TK_CEND = 4'd6, TK_KBYTE = 4'd7,
		TK_KEND = 4'd8, TK_ERR = 4'd9, TK_DONE = 4'd10
	} tok_kind_t;

	// Phase of the byte parser.
	typedef enum logic [2:0] {
		PH_MAGIC, PH_TYPE, PH_FIELD, PH_NUMBER, PH_SLEN, PH_SBODY, PH_KBODY, PH_DONE
	} phase_t;

	// Field purposes.
	localparam logic [4:0] PEND_KEYLEN = 5'd0;
	localparam logic [4:0] PEND_LSTR = 5'd1;
	localparam logic [4:0] PEND_ARRAY = 5'd2;
	localparam logic [4:0] PEND_HASH = 5'd3;
	localparam logic [4:0] PEND_INT = 5'd9;

	// Byte type codes.
	localparam logic [7:0] TB_LSTR = 8'd1;
	localparam logic [7:0] TB_ARRAY = 8'd2;
	localparam logic [7:0] TB_HASH = 8'd3;
	localparam logic [7:0] TB_VECTOR = 8'd4;
	localparam logic [7:0] TB_SMALL = 8'd8;
	localparam logic [7:0] TB_INT = 8'd9;
	localparam logic [7:0] TB_SSTR = 8'd10;
	localparam logic [7:0] TB_SSTR2 = 8'd23;
	localparam logic [31:0] LEN_UNTIL_LOW = 32'd319;
	localparam logic [7:0] LOW_LIMIT = 8'd7;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic push;
		logic push_hash;
		logic [31:0] push_count;
		logic pop;
		logic dec_top;
	} stk_cmd_t;

	// Status from the datapath.
	typedef struct packed {
		logic [SpW-1:0] sp;
		logic top_hash;
		logic [31:0] top_count;
	} stk_stat_t;
endpackage

FILE: design/nrst_stack.sv
// ----------------------------------------------------------------------------
// nrst_stack
// Frame stack datapath: holds one frame per open container.
// ----------------------------------------------------------------------------
module nrst_stack import nrst_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  stk_cmd_t  cmd,
	output stk_stat_t stat
);
	logic [32:0] frame_q [StackDepth];
	logic [SpW-1:0] sp_q;
	logic [IdxW-1:0] top_idx;

	assign top_idx = IdxW'(sp_q - SpW'(1));

	// Stack pointer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q <= '0;
		end else if (cmd.push) begin
			sp_q <= sp_q + SpW'(1);
		end else if (cmd.pop) begin
			sp_q <= sp_q - SpW'(1);
		end
	end

	// Frame storage.
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			frame_q[IdxW'(sp_q)] <= {cmd.push_hash, cmd.push_count};
		end else if (cmd.dec_top) begin
			frame_q[top_idx][31:0] <= frame_q[top_idx][31:0] - 32'd1;
		end
	end

	assign stat.sp = sp_q;
	assign stat.top_hash = frame_q[top_idx][32];
	assign stat.top_count = frame_q[top_idx][31:0];
endmodule

FILE: design/nrst_ctrl.sv
// ----------------------------------------------------------------------------
// nrst_ctrl
// Parser controller: consumes bytes and emits tokens one per cycle at most, holding while the output is stalled.
// ----------------------------------------------------------------------------
`include "nested_record_stream_tokenizer_assert.svh"
module nrst_ctrl import nrst_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [7:0]       in_byte,
	input  logic             in_eob,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [3:0]       out_kind,
	output logic [32:0]      out_value,
	output logic [4:0]       out_depth,
	output logic             out_last,
	output stk_cmd_t         cmd,
	input  stk_stat_t        stat
);
	// Sequencer states: explicit one-hot.
	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,  // waiting for a byte
		S_PROC = 5'b00010,  // handling the held byte
		S_VDONE = 5'b00100, // value completed, walking frames
		S_FIN = 5'b01000,   // end-of-byte checks
		S_DEAD = 5'b10000   // finished, ignore all bytes
	} seq_t;

	seq_t seq_q, seq_d;
	phase_t phase_q, phase_d;
	logic [1:0] magic_q, magic_d;
	logic [31:0] acc_q, acc_d;
	logic [1:0] seen_q, seen_d;
	logic [4:0] pend_q, pend_d;
	logic [31:0] left_q, left_d;
	logic rul_q, rul_d;
	logic [7:0] byte_q;
	logic eob_q;
	logic reparse_q, reparse_d;
	logic fin_q, fin_d;

	// Output register.
	logic ov_q;
	logic [3:0] ok_q;
	logic [32:0] oval_q;
	logic [4:0] odep_q;
	logic olast_q;

	// Staging register: a token waits here until it is known whether
	// another token of the same byte follows it.
	logic hv_q;
	logic [3:0] hk_q;
	logic [32:0] hval_q;
	logic [4:0] hdep_q;

	// Pending token emitted this cycle.
	logic emit;
	logic [3:0] e_kind;
	logic [32:0] e_val;
	logic [SpW-1:0] e_sp;
	logic flush;
	logic load;
	logic out_free;
	logic [31:0] acc_new;
	logic [7:0] xb;

	assign out_free = !ov_q || out_ready;
	assign in_ready = (seq_q == S_IDLE) || (seq_q == S_DEAD);
	assign acc_new = {acc_q[23:0], byte_q};
	assign xb = byte_q ^ 8'h80;

	// Next-state and token logic.
	always_comb begin
		seq_d = seq_q;
		phase_d = phase_q;
		magic_d = magic_q;
		acc_d = acc_q;
		seen_d = seen_q;
		pend_d = pend_q;
		left_d = left_q;
		rul_d = rul_q;
		reparse_d = reparse_q;
		fin_d = fin_q;
		emit = 1'b0;
		e_kind = TK_NIL;
		e_val = '0;
		e_sp = stat.sp;
		flush = 1'b0;
		cmd = '0;
		case (seq_q)
			S_IDLE: begin
				if (in_valid) begin
					seq_d = S_PROC;
					reparse_d = 1'b0;
				end
			end
			S_DEAD: begin
			end
			S_PROC: begin
				if (out_free) begin
					seq_d = S_FIN;
					case (phase_q)
						PH_MAGIC: begin
							magic_d = magic_q - 2'd1;
							if (magic_q == 2'd1) phase_d = PH_TYPE;
						end
						PH_TYPE: begin
							case (byte_q)
								TB_LSTR, TB_ARRAY, TB_HASH, TB_INT: begin
									pend_d = byte_q[4:0];
									acc_d = '0;
									seen_d = '0;
									phase_d = PH_FIELD;
								end
								TB_SMALL: phase_d = PH_NUMBER;
								TB_SSTR, TB_SSTR2: phase_d = PH_SLEN;
								TB_VECTOR: begin
								end
								default: begin
									emit = 1'b1;
									e_kind = TK_NIL;
									seq_d = S_VDONE;
								end
							endcase
						end
						PH_FIELD: begin
							acc_d = acc_new;
							if (seen_q != 2'd3) begin
								seen_d = seen_q + 2'd1;
							end else begin
								seen_d = '0;
								case (pend_q)
									PEND_INT: begin
										emit = 1'b1;
										e_kind = TK_INT;
										e_val = {1'b0, acc_new};
										seq_d = S_VDONE;
									end
									PEND_ARRAY, PEND_HASH: begin
										if (acc_new != '0 && stat.sp >= SpW'(StackDepth)) begin
											emit = 1'b1;
											e_kind = TK_ERR;
											fin_d = 1'b1;
											phase_d = PH_DONE;
										end else begin
											emit = 1'b1;
											e_kind = (pend_q == PEND_HASH) ? TK_HSTART
												: TK_ASTART;
											e_val = {1'b0, acc_new};
											if (acc_new == '0) begin
												// Empty container: no frame is pushed; its end token is deferred.
												seq_d = S_PROC;
												phase_d = PH_NUMBER;
												pend_d = 5'd31;
											end else begin
												cmd.push = 1'b1;
												cmd.push_hash = (pend_q == PEND_HASH);
												cmd.push_count = acc_new;
												phase_d = PH_TYPE;
											end
										end
									end
									default: begin
										// String or key body start.
										phase_d = (pend_q == PEND_LSTR) ? PH_SBODY : PH_KBODY;
										rul_d = 1'b0;
										if (acc_new == LEN_UNTIL_LOW) begin
											rul_d = 1'b1;
										end else if (acc_new == '0) begin
											emit = 1'b1;
											e_kind = (pend_q == PEND_LSTR) ? TK_SEND : TK_KEND;
											seq_d = S_VDONE;
										end else begin
											left_d = acc_new;
										end
									end
								endcase
							end
						end
						PH_NUMBER: begin
							if (pend_q == 5'd31) begin
								// Deferred end token of an empty container.
								emit = 1'b1;
								e_kind = TK_CEND;
								pend_d = '0;
								seq_d = S_VDONE;
							end else begin
								emit = 1'b1;
								e_kind = TK_INT;
								e_val = {{25{xb[7]}}, xb};
								seq_d = S_VDONE;
							end
						end
						PH_SLEN: begin
							phase_d = PH_SBODY;
							rul_d = 1'b0;
							if ({24'd0, byte_q} == '0) begin
								emit = 1'b1;
								e_kind = TK_SEND;
								seq_d = S_VDONE;
							end else begin
								left_d = {24'd0, byte_q};
							end
						end
						PH_SBODY, PH_KBODY: begin
							if (rul_q && byte_q < LOW_LIMIT) begin
								rul_d = 1'b0;
								emit = 1'b1;
								e_kind = (phase_q == PH_KBODY) ? TK_KEND : TK_SEND;
								reparse_d = 1'b1;
								seq_d = S_VDONE;
							end else if (rul_q) begin
								emit = 1'b1;
								e_kind = (phase_q == PH_KBODY) ? TK_KBYTE : TK_SBYTE;
								e_val = {25'd0, byte_q};
							end else begin
								emit = 1'b1;
								e_kind = (phase_q == PH_KBODY) ? TK_KBYTE : TK_SBYTE;
								e_val = {25'd0, byte_q};
								left_d = left_q - 32'd1;
								if (left_q == 32'd1) begin
									// End token follows in the next pass through S_PROC.
									seq_d = S_PROC;
									pend_d = (phase_q == PH_KBODY) ? 5'd30 : 5'd29;
									phase_d = PH_NUMBER;
								end
							end
						end
						default: begin
						end
					endcase
					// Deferred string or key end token.
					if (phase_q == PH_NUMBER && (pend_q == 5'd30 || pend_q == 5'd29)) begin
						emit = 1'b1;
						e_kind = (pend_q == 5'd30) ? TK_KEND : TK_SEND;
						e_val = '0;
						pend_d = '0;
						phase_d = (pend_q == 5'd30) ? PH_KBODY : PH_SBODY;
						seq_d = S_VDONE;
					end
				end
			end
			S_VDONE: begin
				// Body end in key phase means key done; else value done.
				if (out_free) begin
					if (phase_q == PH_KBODY && stat.sp != '0) begin
						if (stat.top_count == 32'd1) begin
							cmd.pop = 1'b1;
							emit = 1'b1;
							e_kind = TK_CEND;
							e_sp = stat.sp - SpW'(1);
							phase_d = PH_TYPE; // then value done
						end else begin
							cmd.dec_top = 1'b1;
							phase_d = PH_TYPE;
							seq_d = S_FIN;
						end
					end else if (stat.sp == '0) begin
						emit = 1'b1;
						e_kind = TK_DONE;
						fin_d = 1'b1;
						phase_d = PH_DONE;
						seq_d = S_FIN;
					end else if (stat.top_hash) begin
						pend_d = PEND_KEYLEN;
						acc_d = '0;
						seen_d = '0;
						phase_d = PH_FIELD;
						seq_d = S_FIN;
					end else if (stat.top_count == 32'd1) begin
						cmd.pop = 1'b1;
						emit = 1'b1;
						e_kind = TK_CEND;
						e_sp = stat.sp - SpW'(1);
						phase_d = PH_TYPE;
					end else begin
						cmd.dec_top = 1'b1;
						phase_d = PH_TYPE;
						seq_d = S_FIN;
					end
				end
			end
			S_FIN: begin
				if (out_free) begin
					if (reparse_q && !fin_q) begin
						reparse_d = 1'b0;
						seq_d = S_PROC;
					end else if (!fin_q && eob_q) begin
						// The error token is released by the next pass through here.
						emit = 1'b1;
						e_kind = TK_ERR;
						fin_d = 1'b1;
						phase_d = PH_DONE;
					end else begin
						// The byte is complete: its staged token is the last one.
						flush = 1'b1;
						seq_d = fin_q ? S_DEAD : S_IDLE;
					end
				end
			end
			default: seq_d = S_IDLE;
		endcase
	end

	// A staged token moves out when the next token arrives or the byte ends.
	assign load = hv_q && (emit || flush);

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q <= S_IDLE;
			phase_q <= PH_MAGIC;
			magic_q <= 2'd2;
			acc_q <= '0;
			seen_q <= '0;
			pend_q <= '0;
			left_q <= '0;
			rul_q <= 1'b0;
			reparse_q <= 1'b0;
			fin_q <= 1'b0;
			ov_q <= 1'b0;
			hv_q <= 1'b0;
		end else begin
			seq_q <= seq_d;
			phase_q <= phase_d;
			magic_q <= magic_d;
			acc_q <= acc_d;
			seen_q <= seen_d;
			pend_q <= pend_d;
			left_q <= left_d;
			rul_q <= rul_d;
			reparse_q <= reparse_d;
			fin_q <= fin_d;
			if (load) begin
				ov_q <= 1'b1;
			end else if (out_ready) begin
				ov_q <= 1'b0;
			end
			if (emit) begin
				hv_q <= 1'b1;
			end else if (flush) begin
				hv_q <= 1'b0;
			end
		end
	end

	// Byte capture, staged token and output payload.
	always_ff @(posedge clk) begin
		if (in_valid && seq_q == S_IDLE) begin
			byte_q <= in_byte;
			eob_q <= in_eob;
		end
		if (load) begin
			ok_q <= hk_q;
			oval_q <= hval_q;
			odep_q <= hdep_q;
			olast_q <= flush;
		end
		if (emit) begin
			hk_q <= e_kind;
			hval_q <= e_val;
			hdep_q <= 5'(e_sp);
		end
	end

	assign out_valid = ov_q;
	assign out_kind = ok_q;
	assign out_value = oval_q;
	assign out_depth = odep_q;
	assign out_last = olast_q;

	`NRST_ASSERT(a_no_push_pop, clk, arst_n, !(cmd.push && cmd.pop), "push and pop together")
	`NRST_ASSERT(a_sp_bound, clk, arst_n, stat.sp <= SpW'(StackDepth), "stack pointer out of range")
	`NRST_ASSERT_NEXT(a_dead_stays, clk, arst_n, seq_q == S_DEAD, seq_q == S_DEAD, "left finished state")
endmodule

FILE: design/nested_record_stream_tokenizer.sv
// ----------------------------------------------------------------------------
// nested_record_stream_tokenizer
// Turns a frozen nested-record blob into a flat token stream.
// ----------------------------------------------------------------------------
// One byte is taken at a time. A byte is accepted, then parsed, then given
// the end-of-byte check. Each further token of the same byte and each step
// of the frame walk adds a pass; nested containers close one frame per
// step, as the frame stack takes one command at a time. A read-until-low
// terminator is parsed a second time, and an error at the end of the blob
// takes a second pass through the end-of-byte check. Every token is staged
// so that its last flag is known, and a stalled output holds the parser.
// After a done or error token the block drops all bytes until reset.
module nested_record_stream_tokenizer import nrst_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        end_of_blob,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [3:0]  token_kind,
	output logic signed [32:0] token_value,
	output logic [4:0]  nest_depth,
	output logic        last_token
);
	stk_cmd_t cmd;
	stk_stat_t stat;
	logic [32:0] val;

	nrst_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_ready,
		.in_byte(data_byte), .in_eob(end_of_blob),
		.out_valid, .out_ready, .out_kind(token_kind), .out_value(val),
		.out_depth(nest_depth), .out_last(last_token), .cmd, .stat
	);

	nrst_stack u_stack (.clk, .arst_n, .cmd, .stat);

	assign token_value = signed'(val);
endmodule

FILE: test/tb_nested_record_stream_tokenizer_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Token stream checker
// Watches the byte and token channels of the tokenizer. It tracks the parse
// state on its own, derives the tokens that each byte transfer must produce,
// and compares every token transfer with the oldest token still owed.
// ----------------------------------------------------------------------------
module tb_nested_record_stream_tokenizer_checker import nrst_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        end_of_blob,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [3:0]  token_kind,
	input  logic signed [32:0] token_value,
	input  logic [4:0]  nest_depth,
	input  logic        last_token,
	output int          errors,
	output int          tokens_owed
);
	localparam int MaxTokens = 40;

	typedef struct {
		tok_kind_t   kind;
		logic [32:0] value;
		logic [4:0]  depth;
		logic        last;
	} token_t;

	// Parser state mirrored from the block's behavior.
	phase_t      phase;
	logic [1:0]  magic_left;
	logic [31:0] field_acc;
	logic [1:0]  field_count;
	logic [4:0]  field_purpose;
	logic [31:0] text_left;
	logic        until_low;
	logic [32:0] frames [StackDepth];
	logic [4:0]  depth;
	logic        halted;

	token_t byte_tokens [$];
	token_t owed_tokens [$];

	function void put(tok_kind_t kind, logic [32:0] value);
		if (byte_tokens.size() < MaxTokens)
			byte_tokens.push_back('{kind, value, depth, 1'b0});
	endfunction

	function void halt(tok_kind_t kind);
		put(kind, '0);
		halted = 1'b1;
		phase = PH_DONE;
	endfunction

	function void begin_field(logic [4:0] purpose);
		field_purpose = purpose;
		field_acc = '0;
		field_count = '0;
		phase = PH_FIELD;
	endfunction

	// A value is complete: walk up through the frames it finishes.
	function void close_value();
		logic [31:0] left;
		forever begin
			if (depth == 0) begin
				halt(TK_DONE);
				return;
			end
			if (frames[depth-1][32]) begin
				begin_field(PEND_KEYLEN);
				return;
			end
			left = frames[depth-1][31:0] - 1;
			if (left != 0) begin
				frames[depth-1] = {1'b0, left};
				phase = PH_TYPE;
				return;
			end
			depth = depth - 1;
			put(TK_CEND, '0);
		end
	endfunction

	// A key is complete: one pair fewer in the hash on top.
	function void close_key();
		logic [31:0] left;
		if (depth == 0) begin
			close_value();
			return;
		end
		left = frames[depth-1][31:0] - 1;
		if (left == 0) begin
			depth = depth - 1;
			put(TK_CEND, '0);
			close_value();
		end else begin
			frames[depth-1] = {1'b1, left};
			phase = PH_TYPE;
		end
	endfunction

	function void finish_text(logic is_key);
		if (is_key)
			close_key();
		else
			close_value();
	endfunction

	function void open_text(logic [31:0] len, logic is_key);
		phase = is_key ? PH_KBODY : PH_SBODY;
		until_low = 1'b0;
		if (len == LEN_UNTIL_LOW) begin
			until_low = 1'b1;
		end else if (len == 0) begin
			put(is_key ? TK_KEND : TK_SEND, '0);
			finish_text(is_key);
		end else begin
			text_left = len;
		end
	endfunction

	function void open_frame(logic is_hash, logic [31:0] count);
		if (count != 0 && depth >= StackDepth) begin
			halt(TK_ERR);
			return;
		end
		put(is_hash ? TK_HSTART : TK_ASTART, {1'b0, count});
		if (count == 0) begin
			put(TK_CEND, '0);
			close_value();
			return;
		end
		frames[depth] = {is_hash, count};
		depth = depth + 1;
		phase = PH_TYPE;
	endfunction

	// Parses one byte; returns 1 when the byte must be parsed once more.
	function bit parse_byte(logic [7:0] b);
		logic       is_key;
		logic [7:0] small_num;
		case (phase)
			PH_MAGIC: begin
				magic_left = magic_left - 1;
				if (magic_left == 0)
					phase = PH_TYPE;
			end
			PH_TYPE: begin
				case (b)
					TB_LSTR, TB_ARRAY, TB_HASH, TB_INT: begin_field(b[4:0]);
					TB_SMALL: phase = PH_NUMBER;
					TB_SSTR, TB_SSTR2: phase = PH_SLEN;
					TB_VECTOR: ;
					default: begin
						put(TK_NIL, '0);
						close_value();
					end
				endcase
			end
			PH_FIELD: begin
				field_acc = {field_acc[23:0], b};
				if (field_count < 3) begin
					field_count = field_count + 1;
				end else begin
					field_count = '0;
					case (field_purpose)
						PEND_INT: begin
							put(TK_INT, {1'b0, field_acc});
							close_value();
						end
						PEND_LSTR: open_text(field_acc, 1'b0);
						PEND_ARRAY: open_frame(1'b0, field_acc);
						PEND_HASH: open_frame(1'b1, field_acc);
						default: open_text(field_acc, 1'b1);
					endcase
				end
			end
			PH_NUMBER: begin
				small_num = b ^ 8'h80;
				put(TK_INT, {{25{small_num[7]}}, small_num});
				close_value();
			end
			PH_SLEN: open_text({24'd0, b}, 1'b0);
			PH_SBODY, PH_KBODY: begin
				is_key = (phase == PH_KBODY);
				if (until_low && b < LOW_LIMIT) begin
					until_low = 1'b0;
					put(is_key ? TK_KEND : TK_SEND, '0);
					finish_text(is_key);
					return 1'b1;
				end
				put(is_key ? TK_KBYTE : TK_SBYTE, {25'd0, b});
				if (!until_low) begin
					text_left = text_left - 1;
					if (text_left == 0) begin
						put(is_key ? TK_KEND : TK_SEND, '0);
						finish_text(is_key);
					end
				end
			end
			default: ;
		endcase
		return 1'b0;
	endfunction

	function void predict_byte(logic [7:0] b, logic eob);
		byte_tokens.delete();
		if (halted)
			return;
		for (int pass = 0; pass < 2 && !halted; pass++)
			if (!parse_byte(b))
				break;
		if (!halted && eob)
			halt(TK_ERR);
		if (byte_tokens.size() > 0)
			byte_tokens[$].last = 1'b1;
		foreach (byte_tokens[i])
			owed_tokens.push_back(byte_tokens[i]);
	endfunction

	// Prediction on byte transfers, comparison on token transfers.
	always @(posedge clk or negedge arst_n) begin
		token_t exp_tok;
		if (!arst_n) begin
			phase = PH_MAGIC;
			magic_left = 2'd2;
			field_acc = '0;
			field_count = '0;
			field_purpose = '0;
			text_left = '0;
			until_low = 1'b0;
			depth = '0;
			halted = 1'b0;
			owed_tokens.delete();
			errors <= 0;
			tokens_owed <= 0;
		end else begin
			if (in_valid && in_ready)
				predict_byte(data_byte, end_of_blob);
			if (out_valid && out_ready) begin
				if (owed_tokens.size() == 0) begin
					$display("%0t: unexpected token kind %0d value %0d depth %0d last %0d",
						$time, token_kind, token_value, nest_depth, last_token);
					errors <= errors + 1;
				end else begin
					exp_tok = owed_tokens.pop_front();
					if (token_kind !== exp_tok.kind || token_value !== exp_tok.value ||
							nest_depth !== exp_tok.depth || last_token !== exp_tok.last) begin
						$display("%0t: token mismatch: expected kind %0d value %0d depth %0d last %0d, got kind %0d value %0d depth %0d last %0d",
							$time, exp_tok.kind, $signed(exp_tok.value), exp_tok.depth,
							exp_tok.last, token_kind, token_value, nest_depth, last_token);
						errors <= errors + 1;
					end
				end
			end
			tokens_owed <= owed_tokens.size();
		end
	end
endmodule

FILE: test/tb_nested_record_stream_tokenizer.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Tokenizer testbench
// Feeds one large well-formed blob, a directed head followed by random
// nested content, through the tokenizer with random gaps on both channels
// and one long receiver stall, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb_nested_record_stream_tokenizer import nrst_pkg::*;;
	localparam logic [7:0] TB_UNDEF = 8'd5;
	localparam int RandomElems = 45;
	localparam int WatchdogLimit = 4000;

	logic clk;
	logic arst_n;
	logic in_valid, in_ready;
	logic [7:0] data_byte;
	logic end_of_blob;
	logic out_valid, out_ready;
	logic [3:0] token_kind;
	logic signed [32:0] token_value;
	logic [4:0] nest_depth;
	logic last_token;
	int errors, tokens_owed;

	logic [8:0] blob_body [$];
	logic [8:0] blob [$];
	bit need_low;
	bit calm;
	int top_elems;
	int tokens_seen;
	int quiet_cycles;

	nested_record_stream_tokenizer dut (.*);

	tb_nested_record_stream_tokenizer_checker checker_inst (.*);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	function void pb(logic [7:0] b);
		blob_body.push_back({1'b0, b});
		need_low = 1'b0;
	endfunction

	function void p32(logic [31:0] v);
		for (int i = 3; i >= 0; i--)
			pb(v[i*8 +: 8]);
	endfunction

	// String or key with a four-byte length; 319 runs until a low byte.
	function automatic void gen_text();
		int n;
		n = ($urandom_range(0, 3) == 0) ? 319 : $urandom_range(0, 6);
		p32(32'(n));
		if (n == 319) begin
			repeat ($urandom_range(0, 5)) pb(8'($urandom_range(7, 255)));
			need_low = 1'b1;
		end else begin
			repeat (n) pb(8'($urandom));
		end
	endfunction

	// One random value object at the given number of open frames.
	function automatic void gen_value(int lvl);
		logic [7:0] tb;
		int n;
		if (need_low) begin
			tb = 8'($urandom_range(0, 6));
		end else begin
			case ($urandom_range(0, 9))
				0: tb = TB_UNDEF;
				1: do tb = 8'($urandom); while (tb inside {TB_LSTR, TB_ARRAY, TB_HASH,
					TB_VECTOR, TB_SMALL, TB_INT, TB_SSTR, TB_SSTR2});
				2: tb = TB_VECTOR;
				3: tb = TB_SMALL;
				4: tb = TB_INT;
				5: tb = TB_SSTR;
				6: tb = TB_SSTR2;
				7: tb = TB_LSTR;
				8: tb = TB_ARRAY;
				default: tb = TB_HASH;
			endcase
		end
		pb(tb);
		case (tb)
			TB_VECTOR: gen_value(lvl);
			TB_SMALL: pb(8'($urandom));
			TB_INT: p32($urandom);
			TB_SSTR, TB_SSTR2: begin
				n = $urandom_range(0, 6);
				pb(8'(n));
				repeat (n) pb(8'($urandom));
			end
			TB_LSTR: gen_text();
			TB_ARRAY, TB_HASH: begin
				n = (lvl < StackDepth && blob_body.size() < 360) ? $urandom_range(0, 3) : 0;
				p32(32'(n));
				repeat (n) begin
					gen_value(lvl + 1);
					if (tb == TB_HASH)
						gen_text();
				end
			end
			default: ;
		endcase
	endfunction

	// Directed head: extremes of each type and the special cases.
	function void gen_directed();
		pb(TB_UNDEF);
		pb(8'd0);
		pb(8'd255);
		pb(TB_VECTOR); pb(TB_SMALL); pb(8'h80);
		pb(TB_SMALL); pb(8'h00);
		pb(TB_SMALL); pb(8'h7F);
		pb(TB_SMALL); pb(8'hFF);
		pb(TB_INT); p32(32'h0000_0000);
		pb(TB_INT); p32(32'hFFFF_FFFF);
		pb(TB_SSTR); pb(8'd0);
		pb(TB_SSTR2); pb(8'd3); pb(8'h00); pb(8'h61); pb(8'hFF);
		pb(TB_LSTR); p32(32'd0);
		// The low byte that ends this string is also the next element.
		pb(TB_LSTR); p32(LEN_UNTIL_LOW); pb(8'd7); pb(8'd200); pb(8'd255);
		pb(TB_UNDEF);
		pb(TB_ARRAY); p32(32'd0);
		pb(TB_HASH); p32(32'd0);
		// Hash with an empty key and a read-until-low key.
		pb(TB_HASH); p32(32'd2);
		pb(TB_UNDEF); p32(32'd0);
		pb(TB_SMALL); pb(8'h81); p32(LEN_UNTIL_LOW); pb(8'd7); pb(8'd8);
		pb(TB_UNDEF);
		// Fill the frame stack, then an empty array at full depth.
		repeat (StackDepth - 1) begin
			pb(TB_ARRAY);
			p32(32'd1);
		end
		pb(TB_ARRAY); p32(32'd0);
		top_elems = 19;
	endfunction

	// Byte sender.
	initial begin
		in_valid <= 1'b0;
		data_byte <= '0;
		end_of_blob <= 1'b0;
		arst_n <= 1'b0;
		calm = 1'b0;
		need_low = 1'b0;
		gen_directed();
		repeat (RandomElems) begin
			gen_value(1);
			top_elems++;
		end
		if (need_low)
			pb(8'd0);
		blob.push_back({1'b0, 8'($urandom)});
		blob.push_back({1'b0, 8'($urandom)});
		blob.push_back({1'b0, TB_ARRAY});
		for (int i = 3; i >= 0; i--)
			blob.push_back({1'b0, 8'(top_elems >> (i * 8))});
		blob = {blob, blob_body};
		blob[$][8] = 1'b1;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (blob[i]) begin
			if (i > blob.size() - 40)
				calm = 1'b1;
			in_valid <= 1'b1;
			data_byte <= blob[i][7:0];
			end_of_blob <= blob[i][8];
			do @(posedge clk); while (!in_ready);
			if (!calm && $urandom_range(0, 4) == 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 4)) @(posedge clk);
			end
		end
		in_valid <= 1'b0;
		calm = 1'b1;
		do @(posedge clk); while (tokens_owed != 0);
		repeat (50) @(posedge clk);
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	// Token receiver: random stalls plus one long hold-off.
	initial begin
		bit held;
		held = 1'b0;
		out_ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (!held && tokens_seen >= 30) begin
				held = 1'b1;
				out_ready <= 1'b0;
				repeat (300) @(posedge clk);
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 4)) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
		end
	end

	// Token count and watchdog on transfer activity.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tokens_seen <= 0;
			quiet_cycles <= 0;
		end else begin
			if (out_valid && out_ready)
				tokens_seen <= tokens_seen + 1;
			if ((out_valid && out_ready) || (in_valid && in_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WatchdogLimit) begin
				$display("== FAIL ==");
				$finish;
			end
		end
	end
endmodule

FILE: filelist.f
+incdir+design
design/nrst_pkg.sv
design/nrst_stack.sv
design/nrst_ctrl.sv
design/nested_record_stream_tokenizer.sv
test/tb_nested_record_stream_tokenizer_checker.sv
test/tb_nested_record_stream_tokenizer.sv
